// ----- src/ssmf_pkg.sv -----
package ssmf_pkg;

   localparam int MAX_BACKGROUND = 128;
   localparam int IDX_W = $clog2(MAX_BACKGROUND);
   localparam int CNT_W = $clog2(MAX_BACKGROUND + 1);
   localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

   localparam int LEVEL_W = 16;
   localparam int SNR_W = 18;
   localparam int FREQ_W = 48;
   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   localparam logic [2:0] REG_BIN_SPACING = 3'd0;
   localparam logic [2:0] REG_CENTER_FREQ = 3'd1;
   localparam logic [2:0] REG_WINDOW_LOW = 3'd2;
   localparam logic [2:0] REG_WINDOW_HIGH = 3'd3;
   localparam logic [2:0] REG_PEAK_LEVEL = 3'd4;
   localparam logic [2:0] REG_CAPACITY = 3'd5;

   localparam logic [31:0] RST_BIN_SPACING = 32'd65536;
   localparam logic [7:0] RST_CAPACITY = 8'd128;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   typedef struct packed {
      logic [31:0] bin_spacing;
      logic [31:0] center_freq;
      logic [31:0] window_low;
      logic [31:0] window_high;
      logic signed [LEVEL_W-1:0] peak_level;
      logic [7:0] background_capacity;
   } cfg_type;

endpackage

// ----- src/ssmf_csr.sv -----
module ssmf_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [ssmf_pkg::ADDR_W-1:0] paddr,
   input  logic [ssmf_pkg::DATA_W-1:0] pwdata,
   output logic [ssmf_pkg::DATA_W-1:0] prdata,
   output logic                        pready,
   output ssmf_pkg::cfg_type           cfg
);
   import ssmf_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic [2:0] index;
   logic write_en;

   assign index = paddr[4:2];
   assign write_en = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            REG_BIN_SPACING: cfg_in.bin_spacing = pwdata;
            REG_CENTER_FREQ: cfg_in.center_freq = pwdata;
            REG_WINDOW_LOW:  cfg_in.window_low = pwdata;
            REG_WINDOW_HIGH: cfg_in.window_high = pwdata;
            REG_PEAK_LEVEL:  cfg_in.peak_level = pwdata[LEVEL_W-1:0];
            REG_CAPACITY:    cfg_in.background_capacity = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_BIN_SPACING: prdata = cfg_ff.bin_spacing;
         REG_CENTER_FREQ: prdata = cfg_ff.center_freq;
         REG_WINDOW_LOW:  prdata = cfg_ff.window_low;
         REG_WINDOW_HIGH: prdata = cfg_ff.window_high;
         REG_PEAK_LEVEL:  prdata = {{(DATA_W-LEVEL_W){cfg_ff.peak_level[LEVEL_W-1]}},
                                    cfg_ff.peak_level};
         REG_CAPACITY:    prdata = {{(DATA_W-8){1'b0}}, cfg_ff.background_capacity};
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bin_spacing <= RST_BIN_SPACING;
         cfg_ff.center_freq <= '0;
         cfg_ff.window_low <= '0;
         cfg_ff.window_high <= '0;
         cfg_ff.peak_level <= '0;
         cfg_ff.background_capacity <= RST_CAPACITY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- src/ssmf_store.sv -----
module ssmf_store (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [ssmf_pkg::IDX_W-1:0]         wr_addr,
   input  logic signed [ssmf_pkg::LEVEL_W-1:0] wr_data,
   input  logic                               rd_en,
   input  logic [ssmf_pkg::IDX_W-1:0]         rd_addr,
   output logic signed [ssmf_pkg::LEVEL_W-1:0] rd_data
);
   import ssmf_pkg::*;

   logic signed [LEVEL_W-1:0] mem [MAX_BACKGROUND];
   logic signed [LEVEL_W-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// ----- src/spectral_snr_median_floor.sv -----
// channel  direction  ports                                         transfer
// req      in         req_bin_level, req_last_bin                   req_valid & req_ready
// rsp      out        rsp_snr_half, rsp_status, rsp_background_count rsp_valid & rsp_ready
// csr      in/out     psel, penable, pwrite, paddr, pwdata, prdata  psel & penable & pwrite
//
// Each bin passes through the frequency difference, its absolute value and the window check;
// a bin inside the window with room in the store then moves down the sorted store, one
// read-compare-write for each stored level it moves past, until it settles in its slot.
// A final bin then goes on to the median reads, the subtraction and the result register.
// Reset clears the count, the frequency and the overflow flag; the store itself is not cleared.
// A final bin waits for the result register to empty; req_ready is low while a bin is worked on.
module spectral_snr_median_floor (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [ssmf_pkg::LEVEL_W-1:0] req_bin_level,
   input  logic                                req_last_bin,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [ssmf_pkg::SNR_W-1:0]   rsp_snr_half,
   output logic [1:0]                          rsp_status,
   output logic [7:0]                          rsp_background_count,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [ssmf_pkg::ADDR_W-1:0]         paddr,
   input  logic [ssmf_pkg::DATA_W-1:0]         pwdata,
   output logic [ssmf_pkg::DATA_W-1:0]         prdata,
   output logic                                pready
);
   import ssmf_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DIFF  = 4'd1;
   localparam logic [3:0] S_ABS   = 4'd2;
   localparam logic [3:0] S_WIN   = 4'd3;
   localparam logic [3:0] S_RD    = 4'd4;
   localparam logic [3:0] S_CMP   = 4'd5;
   localparam logic [3:0] S_MED_A = 4'd6;
   localparam logic [3:0] S_MED_B = 4'd7;
   localparam logic [3:0] S_MED_C = 4'd8;
   localparam logic [3:0] S_OUT   = 4'd9;

   cfg_type cfg;

   logic [3:0] state_ff, state_in;
   logic signed [LEVEL_W-1:0] level_ff, level_in;
   logic last_ff, last_in;
   logic [FREQ_W-1:0] freq_ff, freq_in;
   logic [FREQ_W:0] diff_ff, diff_in;
   logic [FREQ_W-1:0] dist_ff, dist_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic overflow_ff, overflow_in;
   logic signed [LEVEL_W-1:0] med_a_ff, med_a_in;
   logic signed [SNR_W-1:0] snr_ff, snr_in;
   logic [1:0] status_ff, status_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [SNR_W-1:0] rsp_snr_ff, rsp_snr_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [7:0] rsp_count_ff, rsp_count_in;

   logic wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic signed [LEVEL_W-1:0] wr_data;
   logic rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic signed [LEVEL_W-1:0] rd_data;

   logic [CMP_W-1:0] cap;
   logic [CMP_W-1:0] count_wide;
   logic [CNT_W-1:0] half;
   logic [3:0] after_store;
   logic signed [SNR_W:0] twice_median;
   logic signed [SNR_W:0] snr_wide;
   logic out_free;

   ssmf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ssmf_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_snr_half = rsp_snr_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_background_count = rsp_count_ff;

   assign count_wide = CMP_W'(count_ff);
   assign cap = (CMP_W'(cfg.background_capacity) < CMP_W'(MAX_BACKGROUND)) ?
                CMP_W'(cfg.background_capacity) : CMP_W'(MAX_BACKGROUND);
   assign half = count_ff >> 1;
   assign after_store = last_ff ? S_MED_A : S_IDLE;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      level_in = level_ff;
      last_in = last_ff;
      freq_in = freq_ff;
      diff_in = diff_ff;
      dist_in = dist_ff;
      count_in = count_ff;
      pos_in = pos_ff;
      overflow_in = overflow_ff;
      med_a_in = med_a_ff;
      snr_in = snr_ff;
      status_in = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_snr_in = rsp_snr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in = rsp_count_ff;
      wr_en = 1'b0;
      wr_addr = pos_ff;
      wr_data = level_ff;
      rd_en = 1'b0;
      rd_addr = pos_ff - IDX_W'(1);
      twice_median = '0;
      snr_wide = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               level_in = req_bin_level;
               last_in = req_last_bin;
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            diff_in = {1'b0, freq_ff} - {(FREQ_W-31)'(0), cfg.center_freq};
            state_in = S_ABS;
         end
         S_ABS: begin
            dist_in = diff_ff[FREQ_W] ? FREQ_W'(-diff_ff) : diff_ff[FREQ_W-1:0];
            freq_in = freq_ff + FREQ_W'(cfg.bin_spacing);
            state_in = S_WIN;
         end
         S_WIN: begin
            if (dist_ff >= FREQ_W'(cfg.window_low) && dist_ff <= FREQ_W'(cfg.window_high)) begin
               if (count_wide >= cap) begin
                  overflow_in = 1'b1;
                  state_in = after_store;
               end else begin
                  pos_in = count_ff[IDX_W-1:0];
                  state_in = S_RD;
               end
            end else begin
               state_in = after_store;
            end
         end
         S_RD: begin
            // slot at the bottom: drop the level in and finish
            if (pos_ff == '0) begin
               wr_en = 1'b1;
               count_in = count_ff + CNT_W'(1);
               state_in = after_store;
            end else begin
               rd_en = 1'b1;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            wr_en = 1'b1;
            if (rd_data > level_ff) begin
               wr_data = rd_data;
               pos_in = pos_ff - IDX_W'(1);
               state_in = S_RD;
            end else begin
               count_in = count_ff + CNT_W'(1);
               state_in = after_store;
            end
         end
         S_MED_A: begin
            rd_en = 1'b1;
            rd_addr = half[IDX_W-1:0];
            state_in = S_MED_B;
         end
         S_MED_B: begin
            med_a_in = rd_data;
            rd_en = 1'b1;
            rd_addr = half[IDX_W-1:0] - IDX_W'(1);
            state_in = S_MED_C;
         end
         S_MED_C: begin
            if (count_ff[0]) begin
               twice_median = (SNR_W+1)'(med_a_ff) <<< 1;
            end else begin
               twice_median = (SNR_W+1)'(med_a_ff) + (SNR_W+1)'(rd_data);
            end
            snr_wide = ((SNR_W+1)'(cfg.peak_level) <<< 1) - twice_median;
            priority if (overflow_ff) begin
               status_in = STATUS_OVERFLOW;
               snr_in = '0;
            end else if (count_ff == '0) begin
               status_in = STATUS_EMPTY;
               snr_in = '0;
            end else begin
               status_in = STATUS_OK;
               snr_in = snr_wide[SNR_W-1:0];
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            // hold until the result register is free, then start a new spectrum
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_snr_in = snr_ff;
               rsp_status_in = status_ff;
               rsp_count_in = (CMP_W'(count_ff) > CMP_W'(255)) ? 8'd255 : 8'(count_ff);
               count_in = '0;
               freq_in = '0;
               overflow_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         freq_ff <= '0;
         count_ff <= '0;
         overflow_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         freq_ff <= freq_in;
         count_ff <= count_in;
         overflow_ff <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff <= level_in;
      last_ff <= last_in;
      diff_ff <= diff_in;
      dist_ff <= dist_in;
      pos_ff <= pos_in;
      med_a_ff <= med_a_in;
      snr_ff <= snr_in;
      status_ff <= status_in;
      rsp_snr_ff <= rsp_snr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff <= rsp_count_in;
   end

endmodule

// ----- tb/sv/tb_spectral_snr_median_floor.sv -----
module tb_spectral_snr_median_floor;
   import ssmf_pkg::*;

   localparam int SETTLE_CYCLES = 300;
   localparam int HOLD_CYCLES = 2000;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic signed [LEVEL_W-1:0] level;
      logic last;
   } bin_item_type;

   typedef struct packed {
      logic signed [SNR_W-1:0] snr;
      logic [1:0] status;
      logic [7:0] count;
   } snr_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [LEVEL_W-1:0] req_bin_level = '0;
   logic req_last_bin = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [SNR_W-1:0] rsp_snr_half;
   logic [1:0] rsp_status;
   logic [7:0] rsp_background_count;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic pready;

   spectral_snr_median_floor DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_bin_level(req_bin_level),
      .req_last_bin(req_last_bin),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_snr_half(rsp_snr_half),
      .rsp_status(rsp_status),
      .rsp_background_count(rsp_background_count),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state and its copy of the registers
   cfg_type cfg;
   logic signed [LEVEL_W-1:0] floor_levels [MAX_BACKGROUND];
   int floor_count = 0;
   logic [FREQ_W-1:0] freq_acc = '0;
   logic overflow_seen = 1'b0;

   bin_item_type pending_bins [$];
   snr_result_type pending_snr [$];
   int bins_queued = 0;
   int bins_accepted = 0;
   int err_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_token = 0;
   int hold_seen = 0;
   int hold_left = 0;

   task automatic report(input string msg);
      err_count++;
      if (err_count <= REPORT_LIMIT) begin
         $display("%s", msg);
      end
   endtask

   // Advance the spectrum by one bin; on the final bin, produce the SNR over the median floor.
   task automatic absorb_bin(input logic signed [LEVEL_W-1:0] level, input logic last);
      logic [FREQ_W-1:0] center;
      logic [FREQ_W-1:0] distance;
      int cap;
      int pos;
      int n;
      int twice_median;
      int snr;
      snr_result_type res;
      center = {16'd0, cfg.center_freq};
      distance = (freq_acc >= center) ? freq_acc - center : center - freq_acc;
      cap = (int'(cfg.background_capacity) < MAX_BACKGROUND) ?
            int'(cfg.background_capacity) : MAX_BACKGROUND;
      if (distance >= {16'd0, cfg.window_low} && distance <= {16'd0, cfg.window_high}) begin
         if (floor_count >= cap) begin
            overflow_seen = 1'b1;
         end else begin
            pos = floor_count;
            while (pos > 0 && floor_levels[pos-1] > level) begin
               floor_levels[pos] = floor_levels[pos-1];
               pos--;
            end
            floor_levels[pos] = level;
            floor_count++;
         end
      end
      freq_acc = freq_acc + {16'd0, cfg.bin_spacing};
      if (last) begin
         n = floor_count;
         snr = 0;
         if (overflow_seen) begin
            res.status = STATUS_OVERFLOW;
         end else if (n == 0) begin
            res.status = STATUS_EMPTY;
         end else begin
            res.status = STATUS_OK;
            if (n % 2 == 1) begin
               twice_median = 2 * int'(floor_levels[n/2]);
            end else begin
               twice_median = int'(floor_levels[n/2-1]) + int'(floor_levels[n/2]);
            end
            snr = 2 * int'(cfg.peak_level) - twice_median;
         end
         res.snr = snr[SNR_W-1:0];
         res.count = (n > 255) ? 8'd255 : n[7:0];
         pending_snr.push_back(res);
         floor_count = 0;
         freq_acc = '0;
         overflow_seen = 1'b0;
      end
   endtask

   always @(posedge clock) begin : bin_driver
      bin_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         req_bin_level <= '0;
         req_last_bin <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            absorb_bin(req_bin_level, req_last_bin);
            bins_accepted++;
         end
         if (pending_bins.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = pending_bins.pop_front();
            req_valid <= 1'b1;
            req_bin_level <= nxt.level;
            req_last_bin <= nxt.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // hold off for a long stretch whenever a new hold is requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
         hold_seen <= 0;
      end else if (hold_token != hold_seen) begin
         hold_seen <= hold_token;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin : snr_monitor
      snr_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_snr.size() == 0) begin
            report($sformatf("unexpected result snr=%0d status=%0d count=%0d",
                             rsp_snr_half, rsp_status, rsp_background_count));
         end else begin
            want = pending_snr.pop_front();
            if (rsp_snr_half !== want.snr || rsp_status !== want.status ||
                rsp_background_count !== want.count) begin
               report($sformatf("mismatch: snr %0d/%0d status %0d/%0d count %0d/%0d (exp/act)",
                                want.snr, rsp_snr_half, want.status, rsp_status,
                                want.count, rsp_background_count));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[spectral_snr_median_floor] ERROR");
         $finish;
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_BIN_SPACING: cfg.bin_spacing = val;
         REG_CENTER_FREQ: cfg.center_freq = val;
         REG_WINDOW_LOW: cfg.window_low = val;
         REG_WINDOW_HIGH: cfg.window_high = val;
         REG_PEAK_LEVEL: cfg.peak_level = val[LEVEL_W-1:0];
         REG_CAPACITY: cfg.background_capacity = val[7:0];
         default: ;
      endcase
   endtask

   task automatic setup(input logic [31:0] spacing, input logic [31:0] center,
                        input logic [31:0] lo, input logic [31:0] hi,
                        input logic [31:0] peak, input logic [31:0] cap);
      csr_write(REG_BIN_SPACING, spacing);
      csr_write(REG_CENTER_FREQ, center);
      csr_write(REG_WINDOW_LOW, lo);
      csr_write(REG_WINDOW_HIGH, hi);
      csr_write(REG_PEAK_LEVEL, peak);
      csr_write(REG_CAPACITY, cap);
   endtask

   task automatic queue_bin(input logic signed [LEVEL_W-1:0] level, input logic last);
      bin_item_type item;
      item.level = level;
      item.last = last;
      pending_bins.push_back(item);
      bins_queued++;
   endtask

   function automatic logic signed [LEVEL_W-1:0] pick_level();
      logic signed [LEVEL_W-1:0] v;
      case ($urandom_range(9))
         0: v = 16'sh7FFF;
         1: v = 16'sh8000;
         2, 3: v = 16'($urandom_range(8)) - 16'd4;
         default: v = 16'($urandom);
      endcase
      return v;
   endfunction

   task automatic queue_spectrum(input int len);
      for (int i = 0; i < len; i++) begin
         queue_bin(pick_level(), i == len - 1);
      end
   endtask

   task automatic wait_drained();
      while (bins_accepted != bins_queued || pending_snr.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_idling(input int mode);
      @(posedge clock);
      case (mode)
         0: begin send_idle_pct <= 0;  stall_pct <= 0;  end
         1: begin send_idle_pct <= 81; stall_pct <= 0;  end
         2: begin send_idle_pct <= 0;  stall_pct <= 81; end
         default: begin send_idle_pct <= 34; stall_pct <= 34; end
      endcase
   endtask

   // window placed around a few bins so that a fair share of bins land in the store
   task automatic random_setup();
      logic [31:0] spacing;
      logic [31:0] center;
      logic [31:0] lo;
      logic [31:0] hi;
      logic [31:0] cap;
      case ($urandom_range(7))
         0: spacing = $urandom;
         1: spacing = 32'd0;
         default: spacing = ($urandom_range(1, 4) << 16) | ($urandom & 32'hFFFF);
      endcase
      center = spacing * $urandom_range(0, 20);
      lo = spacing * $urandom_range(0, 3);
      hi = lo + spacing * $urandom_range(0, 12) + ($urandom & 32'hFFFF);
      if ($urandom_range(7) == 0) begin
         lo = $urandom;
         hi = $urandom;
      end
      case ($urandom_range(7))
         0: cap = $urandom_range(0, 3);
         1: cap = $urandom_range(129, 255);
         default: cap = $urandom_range(4, 128);
      endcase
      setup(spacing, center, lo, hi, $urandom, cap);
   endtask

   initial begin
      int random_items;
      int phase_items;
      int len;
      cfg.bin_spacing = RST_BIN_SPACING;
      cfg.center_freq = '0;
      cfg.window_low = '0;
      cfg.window_high = '0;
      cfg.peak_level = '0;
      cfg.background_capacity = RST_CAPACITY;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // registers at reset: only the first bin of each spectrum is background
      queue_bin(16'sh7FFF, 1'b1);
      queue_bin(16'sh8000, 1'b0);
      queue_bin(16'sh1234, 1'b1);
      wait_drained();

      // whole spectrum in the window: even and odd medians, ties, extreme results
      setup(32'h0001_0000, 32'h0002_0000, 32'h0, 32'hFFFF_FFFF, 32'h7FFF, 32'd128);
      queue_bin(16'sh8000, 1'b0);
      queue_bin(16'sh7FFF, 1'b1);
      queue_bin(16'sd5, 1'b0);
      queue_bin(16'sd5, 1'b0);
      queue_bin(-16'sd3, 1'b1);
      queue_bin(16'sh8000, 1'b0);
      queue_bin(16'sh8000, 1'b0);
      queue_bin(16'sh8000, 1'b1);
      wait_drained();
      csr_write(REG_PEAK_LEVEL, 32'h8000);
      queue_bin(16'sh7FFF, 1'b1);
      wait_drained();

      // inverted window selects nothing
      csr_write(REG_WINDOW_LOW, 32'hFFFF_FFFF);
      csr_write(REG_WINDOW_HIGH, 32'h0);
      queue_bin(16'sh0100, 1'b0);
      queue_bin(16'sh0200, 1'b1);
      wait_drained();

      // capacity zero and one overflow; the flag clears with the spectrum
      setup(32'h0001_0000, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'd0);
      queue_bin(16'sh0042, 1'b1);
      wait_drained();
      csr_write(REG_CAPACITY, 32'd1);
      queue_bin(16'sh0010, 1'b0);
      queue_bin(16'sh0020, 1'b1);
      queue_bin(16'sh0030, 1'b1);
      wait_drained();

      // zero spacing keeps every bin at the centre; capacity above the store size
      setup(32'h0, 32'h0, 32'h0, 32'h0, 32'h1357, 32'd255);
      queue_spectrum(128);
      queue_spectrum(129);
      wait_drained();

      // widest spacing with the window at its top edge
      setup(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0ABC, 32'd128);
      queue_spectrum(3);
      wait_drained();

      // random spectra over changing settings and idling modes
      random_items = 0;
      for (int ph = 0; ph < 4 || random_items < 200; ph++) begin
         random_setup();
         set_idling(ph % 4);
         phase_items = 0;
         while (phase_items < 50) begin
            len = ($urandom_range(7) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
            queue_spectrum(len);
            phase_items += len;
         end
         random_items += phase_items;
         wait_drained();
      end

      // back pressure: hold the result side while bins keep coming
      random_setup();
      set_idling(0);
      for (int i = 0; i < 12; i++) begin
         queue_spectrum($urandom_range(1, 3));
      end
      @(posedge clock);
      hold_token <= hold_token + 1;
      wait_drained();

      if (err_count == 0) begin
         $display("[spectral_snr_median_floor] OK");
      end else begin
         $display("[spectral_snr_median_floor] ERROR");
      end
      $finish;
   end

endmodule

// ----- files.f -----
src/ssmf_pkg.sv
src/ssmf_csr.sv
src/ssmf_store.sv
src/spectral_snr_median_floor.sv
tb/sv/tb_spectral_snr_median_floor.sv
